/* design/pgsc_pkg.sv */
// Package for the PCM gain/clamp block: word types, formats and constants.
`default_nettype none
package pgsc_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned GainW   = 17;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = GainW;

  localparam logic [GainW-1:0] GainUnity = 17'h10000;
  localparam logic [1:0]       FmtReset  = 2'd0;

  localparam logic [CfgIdxW-1:0] CfgIdxFormat = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxGain   = 1'd1;

  typedef enum logic [1:0] {
    FMT_S16    = 2'd0,
    FMT_S24_32 = 2'd1,
    FMT_S32    = 2'd2,
    FMT_S24_P3 = 2'd3
  } fmt_e;

  typedef struct packed {
    logic [SampleW-1:0] sample_word;
    logic               end_of_block;
  } in_word_t;

  typedef struct packed {
    logic [SampleW-1:0] scaled_word;
    logic               block_done;
  } out_word_t;

  typedef struct packed {
    fmt_e             sample_format;
    logic [GainW-1:0] gain_level;
  } cfg_t;

endpackage
`default_nettype wire

/* design/pcm_gain_scale_clamp.sv */
// Top level of the PCM digital volume block: input register, gain datapath, result register.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | in_word_i  (sample_word, end_of_block)
//   out     | output    | out_valid_o / out_stall_i | out_word_o (scaled_word, block_done)
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled; each accepted word passes
// the input register and then the result register around the multiplier before output.
// Reset empties both stages and loads format 0 and unity gain.
// Output stall holds the result register; the input register keeps taking words while it
// is empty or can move forward, so in_stall_o rises only when both stages are full.
`default_nettype none
module pcm_gain_scale_clamp
  import pgsc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire in_word_t           in_word_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      out_word_t          out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  cfg_t      cfg_q;
  logic      s1_valid_q;
  in_word_t  s1_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t out_word_d;
  logic      out_adv;
  logic      s1_adv;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format <= fmt_e'(FmtReset);
      cfg_q.gain_level    <= GainUnity;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxFormat: cfg_q.sample_format <= fmt_e'(cfg_data_i[1:0]);
        CfgIdxGain:   cfg_q.gain_level    <= cfg_data_i[GainW-1:0];
        default:      cfg_q               <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_word_q <= in_word_i;
    end
    if (out_adv) begin
      out_word_q <= out_word_d;
    end
  end

  pgsc_scale u_scale (
    .cfg_i  (cfg_q),
    .word_i (s1_word_q),
    .word_o (out_word_d)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

/* design/pgsc_scale.sv */
// Gain datapath: sign extend, multiply, round half away from zero, clamp, repack.
`default_nettype none
module pgsc_scale
  import pgsc_pkg::*;
(
  input  cfg_t      cfg_i,
  input  in_word_t  word_i,
  output out_word_t word_o
);

  logic [SampleW-1:0] w;
  logic [SampleW:0]   s;
  logic [SampleW:0]   maxv;
  logic [SampleW-1:0] mask;
  logic               neg;
  logic [SampleW-1:0] mag;
  logic [47:0]        prod;
  logic [SampleW-1:0] q;
  logic [SampleW:0]   qc;
  logic [SampleW:0]   r;
  logic [SampleW-1:0] res;
  logic               bypass;

  assign w = word_i.sample_word;

  always_comb begin
    case (cfg_i.sample_format)
      FMT_S16: begin
        s    = {{17{w[15]}}, w[15:0]};
        maxv = 33'h0_0000_7FFF;
        mask = 32'h0000_FFFF;
      end
      FMT_S32: begin
        s    = {w[31], w};
        maxv = 33'h0_7FFF_FFFF;
        mask = 32'hFFFF_FFFF;
      end
      default: begin
        s    = {{9{w[23]}}, w[23:0]};
        maxv = 33'h0_007F_FFFF;
        mask = 32'h00FF_FFFF;
      end
    endcase
  end

  assign neg  = s[SampleW];
  assign mag  = neg ? SampleW'(-s) : s[SampleW-1:0];
  assign prod = 48'(mag) * 48'(cfg_i.gain_level[15:0]) + 48'd32768;
  assign q    = prod[47:16];

  always_comb begin
    qc = {1'b0, q};
    if (!neg && qc > maxv) begin
      qc = maxv;
    end else if (neg && qc > maxv + 33'd1) begin
      qc = maxv + 33'd1;
    end
  end

  assign r = neg ? -qc : qc;

  // gain at or above unity skips scaling; the format mask is still applied, except for S24_32
  assign bypass = cfg_i.gain_level >= GainUnity;
  assign res    = bypass ? w : r[SampleW-1:0];

  // 24-bit in a 32-bit word keeps its upper byte on bypass
  assign word_o.scaled_word  = (bypass && cfg_i.sample_format == FMT_S24_32) ? res
                                                                             : res & mask;
  assign word_o.block_done   = word_i.end_of_block;

endmodule
`default_nettype wire

/* design/pgsc_checker.sv */
// Port-level assertions for the PCM gain/clamp block, bound to the top level.
`default_nettype none
module pgsc_checker
  import pgsc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_drain_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output word");

endmodule

bind pcm_gain_scale_clamp pgsc_checker u_pgsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire
